/* rtl/lpd_pkg.sv */
// Package for the look-ahead peak detector.
// Holds default widths and configuration register codes; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpd_pkg;

  // Default widths of sample and confirm counter
  localparam int unsigned DEF_SAMPLE_BITS  = 16;
  localparam int unsigned DEF_CONFIRM_BITS = 8;

  // Configuration index width leaves room for unmapped indexes
  localparam int unsigned CFG_INDEX_BITS = 2;

  // Configuration register map
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD   = 2'd0,
    CFG_CONFIRM_LEN = 2'd1
  } cfg_reg_e;

endpackage : lpd_pkg

`default_nettype wire

/* rtl/lookahead_peak_detector_core.sv */
// Top level of the look-ahead peak detector: input register, compare and
// counter update, result register. Depends on lpd_pkg.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   cfg     | cfg_valid_i, cfg_ready_o, cfg_index_i,   | write in
//           | cfg_data_i                               |
//   in      | in_valid_i, in_stall_o, in_sample_i      | beat in
//   out     | out_valid_o, out_stall_i, out_peak_mark_o| beat out
//
// One beat per cycle sustained while the output is not stalled; an accepted
// beat passes through the input register and then the result register, which
// drives the output. The compare against the held peak and the counter
// update happen as the beat moves between the two registers.
// Reset clears the valid flags, the peak state and both config registers.
// A stalled output holds its beat; the input register then fills and
// in_stall_o rises only while the output is both full and stalled.
`timescale 1ns / 1ps
`default_nettype none

module lookahead_peak_detector_core #(
  parameter int unsigned SAMPLE_BITS   = lpd_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned CONFIRM_BITS  = lpd_pkg::DEF_CONFIRM_BITS,
  parameter int unsigned CFG_DATA_BITS =
    (SAMPLE_BITS > CONFIRM_BITS) ? SAMPLE_BITS : CONFIRM_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [lpd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]          cfg_data_i,
  // sample input
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]     in_sample_i,
  // mark output
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   out_peak_mark_o
);
  import lpd_pkg::*;

  localparam logic [CONFIRM_BITS-1:0] CountMax = '1;

  // Config registers
  logic signed [SAMPLE_BITS-1:0]  threshold_q;
  logic        [CONFIRM_BITS-1:0] confirm_len_q;

  // Input register
  logic                          in_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Peak state
  logic signed [SAMPLE_BITS-1:0]  held_peak_q, held_peak_d;
  logic                           peak_active_q, peak_active_d;
  logic        [CONFIRM_BITS-1:0] since_peak_q, since_peak_d;

  // Result register
  logic out_valid_q;
  logic peak_mark_q, peak_mark_d;

  logic advance;
  logic in_take;
  logic signed [SAMPLE_BITS-1:0] ref_level;
  logic above;

  // Move a beat to the result register when it is free or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign out_peak_mark_o = peak_mark_q;

  // Compare against the held peak, or the threshold when nothing is held
  assign ref_level = peak_active_q ? held_peak_q : threshold_q;
  assign above     = sample_q > ref_level;

  // Update peak state and decide the mark
  always_comb begin
    held_peak_d   = held_peak_q;
    peak_active_d = peak_active_q;
    since_peak_d  = since_peak_q;
    peak_mark_d   = 1'b0;
    if (above) begin
      held_peak_d   = sample_q;
      peak_active_d = 1'b1;
      since_peak_d  = '0;
    end else if (peak_active_q && (since_peak_q != CountMax)) begin
      since_peak_d = since_peak_q + 1'b1;
    end
    // Confirm once enough samples passed without a larger one
    if (peak_active_d && (since_peak_d >= confirm_len_q)) begin
      peak_mark_d   = 1'b1;
      peak_active_d = 1'b0;
      since_peak_d  = '0;
    end
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q   <= '0;
      confirm_len_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD:   threshold_q   <= cfg_data_i[SAMPLE_BITS-1:0];
        CFG_CONFIRM_LEN: confirm_len_q <= cfg_data_i[CONFIRM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  // Input payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= in_sample_i;
    end
  end

  // Peak state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_peak_q   <= '0;
      peak_active_q <= 1'b0;
      since_peak_q  <= '0;
      out_valid_q   <= 1'b0;
      peak_mark_q   <= 1'b0;
    end else begin
      if (advance) begin
        held_peak_q   <= held_peak_d;
        peak_active_q <= peak_active_d;
        since_peak_q  <= since_peak_d;
        peak_mark_q   <= peak_mark_d;
        out_valid_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule : lookahead_peak_detector_core

`default_nettype wire

/* rtl/lpd_checker.sv */
// Port-level checker for the look-ahead peak detector, and its bind.
// Depends on lpd_pkg and lookahead_peak_detector_core.
`timescale 1ns / 1ps
`default_nettype none

module lpd_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               cfg_valid_i,
  input wire logic                               cfg_ready_o,
  input wire logic [lpd_pkg::CFG_INDEX_BITS-1:0] cfg_index_i,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic                               out_peak_mark_o
);
  import lpd_pkg::*;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_peak_mark_o))
    else $error("stalled result beat changed");

  // Stall input only while the output is full and stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with free output");

  // An accepted beat reaches the output when the output drains
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i |=> out_valid_o)
    else $error("accepted beat did not reach the output");

  // Config writes are always taken, mapped or not
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i && (cfg_index_i != CFG_THRESHOLD) && (cfg_index_i != CFG_CONFIRM_LEN)
      |-> cfg_ready_o)
    else $error("unmapped config write not taken");

endmodule : lpd_checker

bind lookahead_peak_detector_core lpd_checker u_lpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .cfg_valid_i     (cfg_valid_i),
  .cfg_ready_o     (cfg_ready_o),
  .cfg_index_i     (cfg_index_i),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_peak_mark_o (out_peak_mark_o)
);

`default_nettype wire
